[hw/rtl/imgr_pkg.sv]
// Shared types, constants and helpers for the mean-gradient sharpness block.
// No dependencies.
package imgr_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int FRAC_BITS  = 8;

	localparam int PIX_W   = 8;
	localparam int SIZE_W  = 13;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int SQ_W    = 2 * PIX_W + 1;
	localparam int RAD_W   = SQ_W + 2 * FRAC_BITS - 1;
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int REM_W   = ROOT_W + 4;
	localparam int ACC_W   = 40;
	localparam int MEAN_W  = 16;
	localparam int CNT_W   = COL_W + ROW_W;
	localparam int ADDR_W  = 3;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic valid;
		logic gate;
		logic last;
	} imgr_tag_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} imgr_sqrt_t;

	// clamp a size register to [2, max] and return size - 1
	function automatic logic [COL_W-1:0] size_m1(logic [SIZE_W-1:0] v, int maxv);
		logic [COL_W-1:0] r;
		if (v < SIZE_W'(2))
			r = COL_W'(1);
		else if (v > SIZE_W'(maxv))
			r = COL_W'(maxv - 1);
		else
			r = COL_W'(v - SIZE_W'(1));
		return r;
	endfunction

endpackage

[hw/rtl/imgr_ifs.sv]
// Stream interfaces for pixel requests and frame results.
// Depends on imgr_pkg.
interface imgr_pixel_if import imgr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface imgr_result_if import imgr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] mean_gradient;
	logic [ACC_W-1:0]  gradient_sum;
	modport source (output valid, output mean_gradient, output gradient_sum, input ready);
	modport sink (input valid, input mean_gradient, input gradient_sum, output ready);
endinterface

[hw/rtl/image_mean_gradient.sv]
// Top level of the mean-gradient sharpness block: line memory, difference stage,
// square-root cell chain, accumulator and result register. Depends on imgr_pkg,
// imgr_ifs, imgr_sqrt_cell and imgr_divider.
//
// Usage:
//   pix  - pixel requests, 8-bit gray, raster order; accepted on valid & ready.
//   res  - one result per frame: mean_gradient (Q8.8) and gradient_sum (40 bits).
//   APB  - frame_width at byte address 0, frame_height at 4; sizes clamp to
//          [2, 4096]. Any write restarts the frame counters and the sum.
// Throughput: one pixel per cycle inside a frame. The square root runs through
// a chain of 16 cells, one root bit per cell, so it keeps that pace.
// Result path: after the frame's last pixel is accepted, it passes the neighbor
// and difference registers, the 16 cells, the accumulator and divider load, the
// restoring divider (one quotient bit a cycle), then the result register.
// After the last pixel, pix.ready stays low until the result is taken, so a
// stalled receiver holds the result in its register and stalls the source.
// Reset: sizes return to 640 x 480, counters, sum and neighbors to zero; the
// line memory needs no clearing since row 0 rewrites it before any read counts.
module image_mean_gradient import imgr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	imgr_pixel_if.sink         pix,
	imgr_result_if.source      res
);

	localparam int CELLS = ROOT_W;

	// configuration
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [COL_W-1:0]  wm1;
	logic [ROW_W-1:0]  hm1;
	logic              cfg_wr;

	// frame position and flow control
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             hold_q;
	logic             accept;
	logic             last_px;

	// line memory and neighbors
	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] above_s1;
	logic [PIX_W-1:0] px_s1;
	imgr_tag_t        tag_s1;
	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] upleft_q;
	logic [PIX_W-1:0] dx;
	logic [PIX_W-1:0] dy;
	logic [SQ_W-1:0]  sq_s2;
	imgr_tag_t        tag_s2;

	// root chain
	imgr_tag_t  tag_c  [CELLS+1];
	imgr_sqrt_t data_c [CELLS+1];

	// accumulator and result
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  acc_sum;
	logic [ACC_W-1:0]  sum_q;
	logic              div_start;
	logic              div_done;
	logic [MEAN_W-1:0] div_quo;
	logic [CNT_W-1:0]  pair_count;
	logic              res_valid_q;
	logic [MEAN_W-1:0] mean_q;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;
	assign wm1    = size_m1(width_q, MAX_WIDTH);
	assign hm1    = ROW_W'(size_m1(height_q, MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = 32'(width_q);
			REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Walk the frame; hold the input from the last pixel until the result leaves.
	assign pix.ready = ~hold_q;
	assign accept    = pix.valid & ~hold_q;
	assign last_px   = (col_q == wm1) & (row_q == hm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hold_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_q == wm1) begin
					col_q <= '0;
					row_q <= (row_q == hm1) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (accept & last_px)
				hold_q <= 1'b1;
			else if (res_valid_q & res.ready)
				hold_q <= 1'b0;
		end
	end

	// Read the pixel above before overwriting it with the current one.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[col_q] <= pix.pixel;
			above_s1        <= line_mem[col_q];
			px_s1           <= pix.pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			tag_s2   <= '0;
			left_q   <= '0;
			upleft_q <= '0;
		end else begin
			tag_s1.valid <= accept;
			tag_s1.gate  <= (row_q != '0) & (col_q != '0);
			tag_s1.last  <= last_px;
			tag_s2       <= tag_s1;
			if (tag_s1.valid) begin
				upleft_q <= above_s1;
				left_q   <= px_s1;
			end
		end
	end

	// Differences from the upper-left pixel to its right and lower neighbors.
	assign dx = (above_s1 > upleft_q) ? above_s1 - upleft_q : upleft_q - above_s1;
	assign dy = (left_q > upleft_q) ? left_q - upleft_q : upleft_q - left_q;

	always_ff @(posedge clk) begin
		sq_s2 <= SQ_W'(dx * dx) + SQ_W'(dy * dy);
	end

	// Scale by 2^(2*FRAC_BITS)/2 and feed the root chain.
	assign tag_c[0]       = tag_s2;
	assign data_c[0].rem  = '0;
	assign data_c[0].root = '0;
	assign data_c[0].rad  = {sq_s2, {(2*FRAC_BITS-1){1'b0}}};

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		imgr_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_tag  (tag_c[k]),
			.up_data (data_c[k]),
			.dn_tag  (tag_c[k+1]),
			.dn_data (data_c[k+1])
		);
	end

	// Accumulate; on the frame's last magnitude, capture the sum and divide.
	assign acc_sum = acc_q + (tag_c[CELLS].gate ? ACC_W'(data_c[CELLS].root) : '0);
	assign div_start  = tag_c[CELLS].valid & tag_c[CELLS].last;
	assign pair_count = CNT_W'(wm1) * CNT_W'(hm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cfg_wr) begin
			acc_q <= '0;
		end else if (tag_c[CELLS].valid) begin
			acc_q <= tag_c[CELLS].last ? '0 : acc_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start)
			sum_q <= acc_sum;
		if (div_done)
			mean_q <= div_quo;
	end

	imgr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_sum),
		.divisor  (pair_count),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (div_done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.mean_gradient = mean_q;
	assign res.gradient_sum  = sum_q;

`ifndef ASSERT_OFF
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> hold_q)
		else $error("result pending while input is open");
	a_div_held: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> hold_q)
		else $error("divide started outside end of frame");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= wm1) && (row_q <= hm1))
		else $error("frame position beyond frame size");
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_px) |=> hold_q && !pix.ready)
		else $error("input not held after last pixel");
`endif

endmodule

[hw/rtl/imgr_sqrt_cell.sv]
// One cell of the square-root chain: resolves one root bit per cell.
// Depends on imgr_pkg.
module imgr_sqrt_cell import imgr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  imgr_tag_t  up_tag,
	input  imgr_sqrt_t up_data,
	output imgr_tag_t  dn_tag,
	output imgr_sqrt_t dn_data
);

	imgr_tag_t        tag_q;
	imgr_sqrt_t       data_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	imgr_sqrt_t       data_n;

	always_comb begin
		rem_sh = {up_data.rem[REM_W-3:0], up_data.rad[RAD_W-1 -: 2]};
		trial  = REM_W'({up_data.root, 2'b01});
		data_n.rad = {up_data.rad[RAD_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			data_n.rem  = rem_sh - trial;
			data_n.root = {up_data.root[ROOT_W-2:0], 1'b1};
		end else begin
			data_n.rem  = rem_sh;
			data_n.root = {up_data.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= up_tag;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_n;
	end

	assign dn_tag  = tag_q;
	assign dn_data = data_q;

endmodule

[hw/rtl/imgr_divider.sv]
// Restoring divider, one quotient bit per cycle, for the frame mean.
// Depends on imgr_pkg.
module imgr_divider import imgr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [MEAN_W-1:0] quotient
);

	logic [ACC_W-1:0]          rem_q;
	logic [ACC_W-1:0]          dsh_q;
	logic [MEAN_W-1:0]         quo_q;
	logic [$clog2(MEAN_W)-1:0] step_q;
	logic                      busy_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == $clog2(MEAN_W)'(MEAN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= ACC_W'({divisor, {(MEAN_W-1){1'b0}}});
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[MEAN_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[MEAN_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[dv/tb.sv]
// Self-checking testbench for image_mean_gradient: drives raster frames over the pixel
// stream, programs frame sizes over APB and scores every frame result against a predictor.
// Depends on imgr_pkg, imgr_ifs and the image_mean_gradient RTL.
module tb;
	import imgr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 48;   // wait that outlasts the result path after the last pixel
	localparam int RANDOM_PIXELS = 800;

	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [ACC_W-1:0]  sum;
	} frame_result_t;

	// Predictor of the sharpness metric plus the queue of frame results it expects.
	class gradient_scoreboard;
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		logic [PIX_W-1:0]  line_px[MAX_WIDTH];
		logic [PIX_W-1:0]  left_px;
		logic [PIX_W-1:0]  upleft_px;
		int                col;
		int                row;
		logic [ACC_W-1:0]  acc;
		frame_result_t     frames_due[$];
		int                pixels_seen;
		int                frames_seen;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (line_px[i]) line_px[i] = '0;
			left_px = '0;
			upleft_px = '0;
			col = 0;
			row = 0;
			acc = '0;
			pixels_seen = 0;
			frames_seen = 0;
		endfunction

		static function int clamp_dim(logic [SIZE_W-1:0] v, int maxv);
			if (v < 2) return 2;
			if (v > maxv) return maxv;
			return int'(v);
		endfunction

		function int eff_width();
			return clamp_dim(width_reg, MAX_WIDTH);
		endfunction

		function int eff_height();
			return clamp_dim(height_reg, MAX_HEIGHT);
		endfunction

		static function longint unsigned floor_root(longint unsigned v);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = 17; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v) r = t;
			end
			return r;
		endfunction

		// Q8.8 magnitude of forward differences around the upper-left pixel
		static function longint unsigned grad_q88(int base, int right, int below);
			longint unsigned dx;
			longint unsigned dy;
			dx = (right > base) ? right - base : base - right;
			dy = (below > base) ? below - base : base - below;
			return floor_root(((dx * dx + dy * dy) << (2 * FRAC_BITS)) >> 1);
		endfunction

		function logic [31:0] reg_value(logic idx);
			return (idx == REG_FRAME_WIDTH) ? 32'(width_reg) : 32'(height_reg);
		endfunction

		// any size write restarts the frame; line store and neighbors survive
		function void configure(logic idx, logic [31:0] v);
			if (idx == REG_FRAME_WIDTH) width_reg = v[SIZE_W-1:0];
			else height_reg = v[SIZE_W-1:0];
			col = 0;
			row = 0;
			acc = '0;
		endfunction

		function void note_pixel(logic [PIX_W-1:0] p);
			int w;
			int h;
			int c;
			logic [PIX_W-1:0] above;
			frame_result_t fr;
			w = eff_width();
			h = eff_height();
			c = (col >= w) ? w - 1 : col;
			if (row >= h) row = h - 1;
			above = line_px[c];
			if (row >= 1 && c >= 1)
				acc = acc + ACC_W'(grad_q88(upleft_px, above, left_px));
			upleft_px = above;
			left_px = p;
			line_px[c] = p;
			pixels_seen++;
			if (c + 1 >= w) begin
				col = 0;
				if (row + 1 >= h) begin
					fr.mean = MEAN_W'(acc / (longint'(h - 1) * longint'(w - 1)));
					fr.sum = acc;
					frames_due.push_back(fr);
					row = 0;
					acc = '0;
				end else begin
					row++;
				end
			end else begin
				col = c + 1;
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function bit check_result(logic [MEAN_W-1:0] mean, logic [ACC_W-1:0] sum,
				output string msg);
			frame_result_t fr;
			frames_seen++;
			if (frames_due.size() == 0) begin
				msg = $sformatf("frame result with none expected: mean %0d sum %0d", mean, sum);
				return 0;
			end
			fr = frames_due.pop_front();
			if (mean !== fr.mean || sum !== fr.sum) begin
				msg = $sformatf("frame %0d: mean %0d (want %0d) sum %0d (want %0d)",
					frames_seen, mean, fr.mean, sum, fr.sum);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	imgr_pixel_if  pix_if ();
	imgr_result_if res_if ();

	image_mean_gradient dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.pix    (pix_if.sink),
		.res    (res_if.source)
	);

	gradient_scoreboard sb;
	int mismatches;
	int cfg_writes;
	int src_idle_pct;   // chance per cycle that the pixel source holds off
	int snk_idle_pct;   // chance per cycle that the result sink stalls

	always #5 clk = ~clk;

	task automatic report(input string msg);
		mismatches++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Result sink: stall at random, score every accepted frame result.
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (!sb.check_result(res_if.mean_gradient, res_if.gradient_sum, msg))
					report(msg);
			end
			res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Offer one pixel request, with random hold-off, until it is accepted.
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel <= p;
		do @(posedge clk); while (!pix_if.ready);
		sb.note_pixel(p);
	endtask

	// Drop valid, wait out every pending result, then let the pipeline empty.
	task automatic drain();
		pix_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.configure(idx, v);
		cfg_writes++;
	endtask

	task automatic apb_check(input logic idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(idx) << 2;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.reg_value(idx))
			report($sformatf("register %0d reads %0d, want %0d", idx, prdata,
				sb.reg_value(idx)));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Program both sizes while idle and read them back.
	task automatic set_size(input logic [31:0] w, input logic [31:0] h);
		drain();
		apb_write(REG_FRAME_WIDTH, w);
		apb_write(REG_FRAME_HEIGHT, h);
		apb_check(REG_FRAME_WIDTH);
		apb_check(REG_FRAME_HEIGHT);
	endtask

	// Mostly smooth texture around a random level, sometimes full-range noise.
	function automatic logic [PIX_W-1:0] pick_pixel(int level, bit noisy);
		int v;
		if (noisy) return PIX_W'($urandom_range(255));
		v = level + $urandom_range(16) - 8;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return PIX_W'(v);
	endfunction

	task automatic send_frame(input int npix);
		int level;
		bit noisy;
		level = $urandom_range(255);
		noisy = ($urandom_range(3) == 0);
		for (int i = 0; i < npix; i++) send_pixel(pick_pixel(level, noisy));
	endtask

	initial begin
		int sent;
		int phase;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		res_if.ready = 1'b0;
		sb = new();
		mismatches = 0;
		cfg_writes = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes read back before anything is written
		apb_check(REG_FRAME_WIDTH);
		apb_check(REG_FRAME_HEIGHT);

		// smallest frame with the steepest edges: one magnitude from full swings
		set_size(2, 2);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd255);
		send_pixel(8'd0);
		// flat frame: every difference is zero
		set_size(3, 2);
		for (int i = 0; i < 6; i++) send_pixel(8'd128);
		// sizes below the floor clamp to 2 x 2
		set_size(0, 1);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		// a size write in mid-frame restarts it
		set_size(4, 3);
		for (int i = 0; i < 5; i++) send_pixel(PIX_W'($urandom_range(255)));
		drain();
		apb_write(REG_FRAME_HEIGHT, 3);
		send_frame(12);

		// oversized registers clamp to the maximum: a long partial row, then a
		// tall partial column, each cut off by the next size write
		src_idle_pct = 37;
		snk_idle_pct = 37;
		set_size(13'h1FFF, 2);
		send_frame(300);
		set_size(2, 13'h1FFF);
		send_frame(300);
		set_size(4, 4);

		// random frames across four idling regimes
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			phase = (sent * 4) / RANDOM_PIXELS;
			case (phase)
				0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
				1: begin src_idle_pct = 75; snk_idle_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_idle_pct = 75; end
				default: begin src_idle_pct = 37; snk_idle_pct = 37; end
			endcase
			case ($urandom_range(9))
				0: set_size($urandom_range(1), $urandom_range(12));
				1, 2: ;  // keep the size, frames run back to back
				3: begin
					drain();
					apb_write(REG_FRAME_WIDTH, $urandom_range(2, 12));
				end
				default: set_size($urandom_range(2, 12), $urandom_range(2, 8));
			endcase
			n = sb.eff_width() * sb.eff_height();
			if ($urandom_range(9) == 0) begin
				// abandon the frame part way; the next size write restarts it
				n = $urandom_range(1, n - 1);
				send_frame(n);
				set_size($urandom_range(2, 12), $urandom_range(2, 8));
			end else begin
				send_frame(n);
			end
			sent += n;
		end

		pix_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d pixels, %0d frame results, %0d size writes,",
			sb.pixels_seen, sb.frames_seen, cfg_writes);
		$display("sizes from 2x2 up to partial 4096-wide and 4096-tall frames, four idling regimes.");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("ERROR: run timed out with %0d results pending", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
